// ===== design/bcim_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the block-cyclic index map.
// Holds the payload structs, the setup-to-pipeline geometry struct and the
// one-bit restoring division step used by both the setup sequencer and the pipeline.
package bcim_pkg;

  localparam int IDX_W     = 16;
  localparam int GRID_W    = 8;
  localparam int PDIM_W    = GRID_W + 1;
  localparam int BLK_W     = 13;
  localparam int SIZE_W    = 32;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_W     = 2 * IDX_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MY_ROW      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MY_COL      = 3'd6;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RETRY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FATAL = 2'd2;

  // Request kinds
  localparam logic REQ_ROW = 1'b0;
  localparam logic REQ_COL = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] local_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  global_index;
    logic              index_valid;
    logic [IDX_W-1:0]  local_rows;
    logic [IDX_W-1:0]  local_cols;
    logic [IDX_W-1:0]  local_band_cols;
    logic [SIZE_W-1:0] wavefunction_size;
    logic [SIZE_W-1:0] eij_size;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] rem;
    logic [IDX_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic kind;
    logic ok;
    div_t dv;
  } pstage_t;

  typedef struct packed {
    logic [IDX_W-1:0] nblk;
    logic             last;
    logic             on_grid;
  } prep_t;

  typedef struct packed {
    logic              busy;
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  nb;
    logic [IDX_W-1:0]  pnb_row;
    logic [IDX_W-1:0]  pnb_col;
    logic [IDX_W-1:0]  cnb_row;
    logic [IDX_W-1:0]  cnb_col;
    logic [IDX_W-1:0]  rows;
    logic [IDX_W-1:0]  cols;
    logic [IDX_W-1:0]  bcols;
    logic [SIZE_W-1:0] wf_size;
    logic [SIZE_W-1:0] eij_size;
  } geom_t;

  // One quotient bit: shift the next dividend bit into the remainder, subtract if it fits.
  function automatic div_t div_step(input div_t cur, input logic [IDX_W-1:0] dvs);
    logic [IDX_W:0] trial;
    logic [IDX_W:0] diff;
    div_t           nxt;
    trial = {cur.rem, cur.quo[IDX_W-1]};
    diff  = trial - {1'b0, dvs};
    if (!diff[IDX_W]) begin
      nxt.rem = diff[IDX_W-1:0];
      nxt.quo = {cur.quo[IDX_W-2:0], 1'b1};
    end else begin
      nxt.rem = trial[IDX_W-1:0];
      nxt.quo = {cur.quo[IDX_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

// ===== design/bcim_setup.sv =====
`timescale 1ns / 1ps
// Configuration registers and the setup sequencer of the block-cyclic index map.
// Derives block counts, local counts, buffer sizes and status with a serial divider
// and one shared multiplier; depends on bcim_pkg.
module bcim_setup (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bcim_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcim_pkg::IDX_W-1:0]        cfg_data,
  output bcim_pkg::geom_t                   geom
);

  localparam int IDX_W  = bcim_pkg::IDX_W;
  localparam int GRID_W = bcim_pkg::GRID_W;
  localparam int PDIM_W = bcim_pkg::PDIM_W;
  localparam int BLK_W  = bcim_pkg::BLK_W;
  localparam int SIZE_W = bcim_pkg::SIZE_W;
  localparam int MUL_W  = bcim_pkg::MUL_W;
  localparam int CNT_W  = IDX_W + 1;
  localparam int BIT_W  = $clog2(IDX_W);

  localparam int SQ_W = 3;
  localparam logic [SQ_W-1:0] SQ_LOAD = 3'd0;
  localparam logic [SQ_W-1:0] SQ_DIV  = 3'd1;
  localparam logic [SQ_W-1:0] SQ_PREP = 3'd2;
  localparam logic [SQ_W-1:0] SQ_MUL  = 3'd3;
  localparam logic [SQ_W-1:0] SQ_CNT  = 3'd4;
  localparam logic [SQ_W-1:0] SQ_SIZE = 3'd5;
  localparam logic [SQ_W-1:0] SQ_DONE = 3'd6;

  localparam int OP_W = 3;
  // divider operations
  localparam logic [OP_W-1:0] OP_BLK  = 3'd0;
  localparam logic [OP_W-1:0] OP_BBLK = 3'd1;
  localparam logic [OP_W-1:0] OP_ROWS = 3'd2;
  localparam logic [OP_W-1:0] OP_COLS = 3'd3;
  localparam logic [OP_W-1:0] OP_BAND = 3'd4;
  // multiplier operations
  localparam logic [OP_W-1:0] MOP_ROWS    = 3'd0;
  localparam logic [OP_W-1:0] MOP_COLS    = 3'd1;
  localparam logic [OP_W-1:0] MOP_BAND    = 3'd2;
  localparam logic [OP_W-1:0] MOP_PNB_ROW = 3'd3;
  localparam logic [OP_W-1:0] MOP_PNB_COL = 3'd4;
  localparam logic [OP_W-1:0] MOP_CNB_ROW = 3'd5;
  localparam logic [OP_W-1:0] MOP_CNB_COL = 3'd6;
  // size operations
  localparam logic [OP_W-1:0] SOP_WF  = 3'd0;
  localparam logic [OP_W-1:0] SOP_EIJ = 3'd1;

  logic [IDX_W-1:0]  ms_r, bc_r;
  logic [BLK_W-1:0]  bs_r;
  logic [PDIM_W-1:0] pr_r, pc_r;
  logic [GRID_W-1:0] myr_r, myc_r;

  logic [BLK_W-1:0]  nb;
  logic [PDIM_W-1:0] pr_eff, pc_eff;

  logic [SQ_W-1:0]   sq_r;
  logic [OP_W-1:0]   op_r;
  logic [BIT_W-1:0]  bit_r;
  logic              div_last;

  bcim_pkg::div_t    dv_r, dv_step;
  logic [IDX_W-1:0]  dvs_r, dvd, dvs;

  logic [IDX_W-1:0]  blk_r, bblk_r;
  logic [BLK_W-1:0]  tailm_r, tailb_r;
  logic [IDX_W-1:0]  qr_r, qc_r, qb_r;
  logic [PDIM_W-1:0] rr_r, rc_r, rb_r;
  bcim_pkg::prep_t   prep_row_r, prep_col_r, prep_band_r;
  logic [CNT_W-1:0]  prod_row_r, prod_col_r, prod_band_r;
  logic [IDX_W-1:0]  pnbr_r, pnbc_r, cnbr_r, cnbc_r;
  logic [IDX_W-1:0]  rows_r, cols_r, bcols_r;
  logic [SIZE_W-1:0] wf_r, eij_r;
  logic [bcim_pkg::STAT_W-1:0] status_r;
  logic              fail;

  logic [IDX_W-1:0]  mul_a, mul_b;
  logic [MUL_W-1:0]  mul_p;

  function automatic bcim_pkg::prep_t prep_fn(input logic [IDX_W-1:0] q,
                                              input logic [PDIM_W-1:0] r,
                                              input logic [PDIM_W-1:0] p,
                                              input logic [GRID_W-1:0] c);
    logic [PDIM_W-1:0] cx;
    logic [PDIM_W-1:0] last;
    bcim_pkg::prep_t   res;
    cx          = PDIM_W'(c);
    last        = (r == '0) ? p - PDIM_W'(1) : r - PDIM_W'(1);
    res.nblk    = q + IDX_W'(cx < r);
    res.last    = (cx == last);
    res.on_grid = (cx < p);
    return res;
  endfunction

  // Last holder gets a short final block: drop one full block, add the tail.
  function automatic logic [IDX_W-1:0] count_fn(input bcim_pkg::prep_t pp,
                                                input logic [CNT_W-1:0] prod,
                                                input logic [BLK_W-1:0] nbv,
                                                input logic [BLK_W-1:0] tail);
    logic [CNT_W-1:0] full;
    logic [IDX_W-1:0] res;
    full = prod - CNT_W'(nbv) + CNT_W'(tail);
    if (!pp.on_grid || pp.nblk == '0) begin
      res = '0;
    end else if (pp.last) begin
      res = full[IDX_W-1:0];
    end else begin
      res = prod[IDX_W-1:0];
    end
    return res;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r  <= IDX_W'(1);
      bc_r  <= IDX_W'(1);
      bs_r  <= BLK_W'(1);
      pr_r  <= PDIM_W'(1);
      pc_r  <= PDIM_W'(1);
      myr_r <= '0;
      myc_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bcim_pkg::CFG_MATRIX_SIZE: ms_r  <= cfg_data;
        bcim_pkg::CFG_BAND_COUNT:  bc_r  <= cfg_data;
        bcim_pkg::CFG_BLOCK_SIZE:  bs_r  <= cfg_data[BLK_W-1:0];
        bcim_pkg::CFG_GRID_ROWS:   pr_r  <= cfg_data[PDIM_W-1:0];
        bcim_pkg::CFG_GRID_COLS:   pc_r  <= cfg_data[PDIM_W-1:0];
        bcim_pkg::CFG_MY_ROW:      myr_r <= cfg_data[GRID_W-1:0];
        bcim_pkg::CFG_MY_COL:      myc_r <= cfg_data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // zero block size or grid dimension acts as one
  assign nb     = (bs_r == '0) ? BLK_W'(1) : bs_r;
  assign pr_eff = (pr_r == '0) ? PDIM_W'(1) : pr_r;
  assign pc_eff = (pc_r == '0) ? PDIM_W'(1) : pc_r;

  always_comb begin
    dvd = '0;
    dvs = IDX_W'(nb);
    case (op_r)
      OP_BLK:  dvd = ms_r;
      OP_BBLK: dvd = bc_r;
      OP_ROWS: begin
        dvd = blk_r;
        dvs = IDX_W'(pr_eff);
      end
      OP_COLS: begin
        dvd = blk_r;
        dvs = IDX_W'(pc_eff);
      end
      OP_BAND: begin
        dvd = bblk_r;
        dvs = IDX_W'(pc_eff);
      end
      default: ;
    endcase
  end

  assign dv_step  = bcim_pkg::div_step(dv_r, dvs_r);
  assign div_last = (bit_r == BIT_W'(IDX_W - 1));

  always_comb begin
    mul_a = '0;
    mul_b = IDX_W'(nb);
    if (sq_r == SQ_SIZE) begin
      mul_a = bcols_r;
      mul_b = (op_r == SOP_WF) ? rows_r : bcols_r;
    end else begin
      case (op_r)
        MOP_ROWS:    mul_a = prep_row_r.nblk;
        MOP_COLS:    mul_a = prep_col_r.nblk;
        MOP_BAND:    mul_a = prep_band_r.nblk;
        MOP_PNB_ROW: mul_a = IDX_W'(pr_eff);
        MOP_PNB_COL: mul_a = IDX_W'(pc_eff);
        MOP_CNB_ROW: mul_a = IDX_W'(myr_r);
        MOP_CNB_COL: mul_a = IDX_W'(myc_r);
        default: ;
      endcase
    end
  end

  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  assign fail = (IDX_W'(pr_eff) > blk_r) || (IDX_W'(pc_eff) > blk_r) ||
                (IDX_W'(pc_eff) > bblk_r);

  // sequencer control; any config write restarts the run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r  <= SQ_LOAD;
      op_r  <= '0;
      bit_r <= '0;
    end else if (cfg_valid) begin
      sq_r  <= SQ_LOAD;
      op_r  <= '0;
      bit_r <= '0;
    end else begin
      unique case (sq_r)
        SQ_LOAD: begin
          sq_r  <= SQ_DIV;
          bit_r <= '0;
        end
        SQ_DIV: begin
          if (div_last) begin
            bit_r <= '0;
            if (op_r == OP_BAND) begin
              sq_r <= SQ_PREP;
              op_r <= '0;
            end else begin
              sq_r <= SQ_LOAD;
              op_r <= op_r + OP_W'(1);
            end
          end else begin
            bit_r <= bit_r + BIT_W'(1);
          end
        end
        SQ_PREP: begin
          sq_r <= SQ_MUL;
          op_r <= '0;
        end
        SQ_MUL: begin
          if (op_r == MOP_CNB_COL) begin
            sq_r <= SQ_CNT;
            op_r <= '0;
          end else begin
            op_r <= op_r + OP_W'(1);
          end
        end
        SQ_CNT: begin
          sq_r <= SQ_SIZE;
          op_r <= '0;
        end
        SQ_SIZE: begin
          if (op_r == SOP_EIJ) begin
            sq_r <= SQ_DONE;
          end else begin
            op_r <= op_r + OP_W'(1);
          end
        end
        SQ_DONE: ;
        default: sq_r <= SQ_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sq_r == SQ_LOAD) begin
      dv_r.rem <= '0;
      dv_r.quo <= dvd;
      dvs_r    <= dvs;
    end
    if (sq_r == SQ_DIV) begin
      dv_r <= dv_step;
      if (div_last) begin
        case (op_r)
          OP_BLK: begin
            blk_r   <= dv_step.quo + IDX_W'(|dv_step.rem);
            tailm_r <= (dv_step.rem == '0) ? nb : dv_step.rem[BLK_W-1:0];
          end
          OP_BBLK: begin
            bblk_r  <= dv_step.quo + IDX_W'(|dv_step.rem);
            tailb_r <= (dv_step.rem == '0) ? nb : dv_step.rem[BLK_W-1:0];
          end
          OP_ROWS: begin
            qr_r <= dv_step.quo;
            rr_r <= dv_step.rem[PDIM_W-1:0];
          end
          OP_COLS: begin
            qc_r <= dv_step.quo;
            rc_r <= dv_step.rem[PDIM_W-1:0];
          end
          OP_BAND: begin
            qb_r <= dv_step.quo;
            rb_r <= dv_step.rem[PDIM_W-1:0];
          end
          default: ;
        endcase
      end
    end
    if (sq_r == SQ_PREP) begin
      prep_row_r  <= prep_fn(qr_r, rr_r, pr_eff, myr_r);
      prep_col_r  <= prep_fn(qc_r, rc_r, pc_eff, myc_r);
      prep_band_r <= prep_fn(qb_r, rb_r, pc_eff, myc_r);
      if (fail) begin
        status_r <= (nb > BLK_W'(1)) ? bcim_pkg::ST_RETRY : bcim_pkg::ST_FATAL;
      end else begin
        status_r <= bcim_pkg::ST_OK;
      end
    end
    if (sq_r == SQ_MUL) begin
      case (op_r)
        MOP_ROWS:    prod_row_r  <= mul_p[CNT_W-1:0];
        MOP_COLS:    prod_col_r  <= mul_p[CNT_W-1:0];
        MOP_BAND:    prod_band_r <= mul_p[CNT_W-1:0];
        MOP_PNB_ROW: pnbr_r      <= mul_p[IDX_W-1:0];
        MOP_PNB_COL: pnbc_r      <= mul_p[IDX_W-1:0];
        MOP_CNB_ROW: cnbr_r      <= mul_p[IDX_W-1:0];
        MOP_CNB_COL: cnbc_r      <= mul_p[IDX_W-1:0];
        default: ;
      endcase
    end
    if (sq_r == SQ_CNT) begin
      rows_r  <= count_fn(prep_row_r, prod_row_r, nb, tailm_r);
      cols_r  <= count_fn(prep_col_r, prod_col_r, nb, tailm_r);
      bcols_r <= count_fn(prep_band_r, prod_band_r, nb, tailb_r);
    end
    if (sq_r == SQ_SIZE) begin
      if (op_r == SOP_WF) begin
        wf_r <= mul_p[SIZE_W-1:0];
      end else begin
        eij_r <= mul_p[SIZE_W-1:0];
      end
    end
  end

  always_comb begin
    geom.busy     = (sq_r != SQ_DONE) || cfg_valid;
    geom.status   = status_r;
    geom.nb       = nb;
    geom.pnb_row  = pnbr_r;
    geom.pnb_col  = pnbc_r;
    geom.cnb_row  = cnbr_r;
    geom.cnb_col  = cnbc_r;
    geom.rows     = rows_r;
    geom.cols     = cols_r;
    geom.bcols    = bcols_r;
    geom.wf_size  = wf_r;
    geom.eij_size = eij_r;
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> (sq_r == SQ_LOAD && op_r == OP_BLK))
    else $error("setup run not restarted after config transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_r == SQ_DONE && status_r == bcim_pkg::ST_OK) |->
      (rows_r <= ms_r && cols_r <= ms_r && bcols_r <= bc_r))
    else $error("local count exceeds global size");

endmodule

// ===== design/block_cyclic_index_map.sv =====
`timescale 1ns / 1ps
// Block-cyclic index map: usage
//   Configuration: write registers through cfg_valid/cfg_ready (cfg_ready is always
//   high), cfg_index selects the register, cfg_data carries the value. Write only
//   while no request is in flight.
//   After reset and after every configuration transfer a setup run (five serial
//   divisions on the shared divider, seven multiplies, then count and size steps
//   on the shared multiplier) computes the local counts, buffer sizes and status;
//   in_stall is high during that run.
//   Requests: in_item transfers when in_valid is high and in_stall is low. Each
//   request gives exactly one result on out_item, transferred when out_valid is
//   high and out_stall is low, in request order.
//   Path: each request passes the input stage, the 16-stage bit-per-stage divider
//   of the local index by block_size, the multiply stage and the output register.
//   Throughput: one request per cycle. When out_stall is high the pipeline holds;
//   empty stages still fill, so in_stall rises only once every stage holds an item.
//   Depends on bcim_pkg and bcim_setup.
module block_cyclic_index_map (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bcim_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bcim_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bcim_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcim_pkg::IDX_W-1:0]     cfg_data
);

  localparam int IDX_W = bcim_pkg::IDX_W;
  localparam int MUL_W = bcim_pkg::MUL_W;
  localparam int NDIV  = IDX_W;

  bcim_pkg::geom_t     geom;

  logic [NDIV:0]       dvld_r;
  logic [NDIV:0]       drdy;
  bcim_pkg::pstage_t   dst_r [NDIV+1];

  logic                mvld_r, mrdy;
  logic                m_kind_r, m_ok_r;
  logic [IDX_W-1:0]    m_prod_r, m_rem_r;

  logic                ovld_r, ordy;
  bcim_pkg::out_item_t out_r, out_nxt;

  logic [IDX_W-1:0]    nb_x, cnt_sel, pnb_sel, cnb_sel, g_sum;
  logic [MUL_W-1:0]    mul_q;

  bcim_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  assign nb_x = IDX_W'(geom.nb);

  // a stage may advance when it or any later stage is empty, or the multiply stage moves
  assign ordy = !ovld_r || !out_stall;
  assign mrdy = !mvld_r || ordy;

  genvar gk;
  generate
    for (gk = 0; gk <= NDIV; gk++) begin : g_rdy
      assign drdy[gk] = !(&dvld_r[NDIV:gk]) || mrdy;
    end
  endgenerate

  assign in_stall = !drdy[0] || geom.busy;

  assign cnt_sel = (in_item.req_type == bcim_pkg::REQ_COL) ? geom.cols : geom.rows;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r <= '0;
      mvld_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      if (drdy[0]) begin
        dvld_r[0] <= in_valid && !geom.busy;
      end
      for (int k = 1; k <= NDIV; k++) begin
        if (drdy[k]) begin
          dvld_r[k] <= dvld_r[k-1];
        end
      end
      if (mrdy) begin
        mvld_r <= dvld_r[NDIV];
      end
      if (ordy) begin
        ovld_r <= mvld_r;
      end
    end
  end

  // divider chain: stage k holds k quotient bits of local_index / block_size
  always_ff @(posedge clk) begin
    if (drdy[0]) begin
      dst_r[0].kind   <= in_item.req_type;
      dst_r[0].ok     <= (in_item.local_index < cnt_sel);
      dst_r[0].dv.rem <= '0;
      dst_r[0].dv.quo <= in_item.local_index;
    end
    for (int k = 1; k <= NDIV; k++) begin
      if (drdy[k]) begin
        dst_r[k].kind <= dst_r[k-1].kind;
        dst_r[k].ok   <= dst_r[k-1].ok;
        dst_r[k].dv   <= bcim_pkg::div_step(dst_r[k-1].dv, nb_x);
      end
    end
  end

  // block number times grid dim times block size, modulo the index width
  assign pnb_sel = (dst_r[NDIV].kind == bcim_pkg::REQ_COL) ? geom.pnb_col : geom.pnb_row;
  assign mul_q   = MUL_W'(dst_r[NDIV].dv.quo) * MUL_W'(pnb_sel);

  always_ff @(posedge clk) begin
    if (mrdy) begin
      m_kind_r <= dst_r[NDIV].kind;
      m_ok_r   <= dst_r[NDIV].ok;
      m_rem_r  <= dst_r[NDIV].dv.rem;
      m_prod_r <= mul_q[IDX_W-1:0];
    end
  end

  assign cnb_sel = (m_kind_r == bcim_pkg::REQ_COL) ? geom.cnb_col : geom.cnb_row;
  assign g_sum   = m_prod_r + cnb_sel + m_rem_r;

  always_comb begin
    out_nxt        = '0;
    out_nxt.status = geom.status;
    if (geom.status == bcim_pkg::ST_OK) begin
      out_nxt.global_index      = m_ok_r ? g_sum : '0;
      out_nxt.index_valid       = m_ok_r;
      out_nxt.local_rows        = geom.rows;
      out_nxt.local_cols        = geom.cols;
      out_nxt.local_band_cols   = geom.bcols;
      out_nxt.wavefunction_size = geom.wf_size;
      out_nxt.eij_size          = geom.eij_size;
    end
  end

  always_ff @(posedge clk) begin
    if (ordy) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = ovld_r;
  assign out_item  = out_r;

  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.index_valid) |-> (out_item.status == bcim_pkg::ST_OK))
    else $error("valid index reported with failing status");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.index_valid) |-> (out_item.global_index == '0))
    else $error("invalid index carries nonzero global index");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(mvld_r))
    else $error("result appeared without an item in the multiply stage");

endmodule

// ===== verif/block_cyclic_index_map_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for block_cyclic_index_map: directed table, then random setups.
// Expected results come from an in-bench block-cyclic count and index predictor.
// Depends on bcim_pkg and the block_cyclic_index_map RTL.
module block_cyclic_index_map_tb;

  localparam int IDX_W     = bcim_pkg::IDX_W;
  localparam int GRID_W    = bcim_pkg::GRID_W;
  localparam int PDIM_W    = bcim_pkg::PDIM_W;
  localparam int BLK_W     = bcim_pkg::BLK_W;
  localparam int SIZE_W    = bcim_pkg::SIZE_W;
  localparam int STAT_W    = bcim_pkg::STAT_W;
  localparam int CFG_IDX_W = bcim_pkg::CFG_IDX_W;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned PHASES       = 14;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned TAIL_CYCLES  = 40;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [IDX_W-1:0]     reg_val;
    bcim_pkg::in_item_t   item;
    logic                 typed;
    bcim_pkg::out_item_t  want;
  } dir_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  bcim_pkg::in_item_t   in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  bcim_pkg::out_item_t  out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [IDX_W-1:0]     cfg_data  = '0;

  // Shadow of the block's registers, reset values included
  logic [IDX_W-1:0]  sh_matrix = 16'd1;
  logic [IDX_W-1:0]  sh_band   = 16'd1;
  logic [BLK_W-1:0]  sh_block  = 13'd1;
  logic [PDIM_W-1:0] sh_grid_r = 9'd1;
  logic [PDIM_W-1:0] sh_grid_c = 9'd1;
  logic [GRID_W-1:0] sh_row    = 8'd0;
  logic [GRID_W-1:0] sh_col    = 8'd0;

  bcim_pkg::out_item_t results_due [$];
  dir_row_t            dir_tab [$];
  bcim_pkg::out_item_t head_want;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_mode  = 0;
  int unsigned stall_left  = 0;
  int unsigned run_left    = 0;

  block_cyclic_index_map u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Elements of an n-long dimension owned by coordinate c on a p-wide grid axis
  function automatic logic [63:0] share_of(input logic [63:0] n, input logic [63:0] nb,
                                           input logic [63:0] p, input logic [63:0] c);
    logic [63:0] blk;
    logic [63:0] nblk;
    logic [63:0] tail;
    blk = (n + nb - 64'd1) / nb;
    if (c >= p || blk == 64'd0) return 64'd0;
    nblk = blk / p + ((c < blk % p) ? 64'd1 : 64'd0);
    tail = (blk % p == 64'd0) ? p - 64'd1 : blk % p - 64'd1;
    if (nblk == 64'd0) return 64'd0;
    if (c == tail) return (nblk - 64'd1) * nb + (n - (blk - 64'd1) * nb);
    return nblk * nb;
  endfunction

  function automatic bcim_pkg::out_item_t map_index(input bcim_pkg::in_item_t it);
    logic [63:0] nb, pr, pc, ms, bc, blk, bblk;
    logic [63:0] rows, cols, bcols, p, c, cnt, l, g, wf, eij;
    bcim_pkg::out_item_t r;
    r    = '0;
    ms   = 64'(sh_matrix);
    bc   = 64'(sh_band);
    nb   = (sh_block == '0) ? 64'd1 : 64'(sh_block);
    pr   = (sh_grid_r == '0) ? 64'd1 : 64'(sh_grid_r);
    pc   = (sh_grid_c == '0) ? 64'd1 : 64'(sh_grid_c);
    blk  = (ms + nb - 64'd1) / nb;
    bblk = (bc + nb - 64'd1) / nb;
    if (pr > blk || pc > blk || pc > bblk) begin
      r.status = (nb > 64'd1) ? bcim_pkg::ST_RETRY : bcim_pkg::ST_FATAL;
      return r;
    end
    rows  = share_of(ms, nb, pr, 64'(sh_row));
    cols  = share_of(ms, nb, pc, 64'(sh_col));
    bcols = share_of(bc, nb, pc, 64'(sh_col));
    if (it.req_type == bcim_pkg::REQ_ROW) begin
      p = pr; c = 64'(sh_row); cnt = rows;
    end else begin
      p = pc; c = 64'(sh_col); cnt = cols;
    end
    l = 64'(it.local_index);
    if (l < cnt) begin
      g = ((l / nb) * p + c) * nb + l % nb;
      r.index_valid  = 1'b1;
      r.global_index = g[IDX_W-1:0];
    end
    wf  = bcols * rows;
    eij = bcols * bcols;
    r.local_rows        = rows[IDX_W-1:0];
    r.local_cols        = cols[IDX_W-1:0];
    r.local_band_cols   = bcols[IDX_W-1:0];
    r.wavefunction_size = wf[SIZE_W-1:0];
    r.eij_size          = eij[SIZE_W-1:0];
    r.status            = bcim_pkg::ST_OK;
    return r;
  endfunction

  function automatic bcim_pkg::out_item_t result_of(input logic [IDX_W-1:0] g, input logic v,
                                                    input logic [IDX_W-1:0] rows,
                                                    input logic [IDX_W-1:0] cols,
                                                    input logic [IDX_W-1:0] bcols,
                                                    input logic [SIZE_W-1:0] wf,
                                                    input logic [SIZE_W-1:0] eij,
                                                    input logic [STAT_W-1:0] st);
    bcim_pkg::out_item_t r;
    r.global_index      = g;
    r.index_valid       = v;
    r.local_rows        = rows;
    r.local_cols        = cols;
    r.local_band_cols   = bcols;
    r.wavefunction_size = wf;
    r.eij_size          = eij;
    r.status            = st;
    return r;
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [IDX_W-1:0] val);
    dir_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_req(input logic kind, input logic [IDX_W-1:0] l,
                                  input logic typed, input bcim_pkg::out_item_t want);
    dir_row_t row;
    row                  = '0;
    row.item.req_type    = kind;
    row.item.local_index = l;
    row.typed            = typed;
    row.want             = want;
    dir_tab.push_back(row);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IDX_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bcim_pkg::CFG_MATRIX_SIZE: sh_matrix = val;
      bcim_pkg::CFG_BAND_COUNT:  sh_band   = val;
      bcim_pkg::CFG_BLOCK_SIZE:  sh_block  = val[BLK_W-1:0];
      bcim_pkg::CFG_GRID_ROWS:   sh_grid_r = val[PDIM_W-1:0];
      bcim_pkg::CFG_GRID_COLS:   sh_grid_c = val[PDIM_W-1:0];
      bcim_pkg::CFG_MY_ROW:      sh_row    = val[GRID_W-1:0];
      bcim_pkg::CFG_MY_COL:      sh_col    = val[GRID_W-1:0];
      default: ;
    endcase
  endtask

  // Hold the item until it transfers, then record what it must produce
  task automatic send_item(input bcim_pkg::in_item_t it, input logic typed,
                           input bcim_pkg::out_item_t want);
    int unsigned gap;
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    results_due.push_back(typed ? want : map_index(it));
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 4);
    if (r < 85) return $urandom_range(5, 32);
    return $urandom_range(33, 256);
  endfunction

  // Mostly setups that pass the block-count check with coordinates on the grid
  task automatic random_setup();
    int unsigned pr, pc, mx, nb, hi, lo, ms, bc, r;
    logic [GRID_W-1:0] rr, cc;
    if ($urandom_range(0, 9) < 7) begin
      pr = pick_dim();
      pc = pick_dim();
      mx = (pr > pc) ? pr : pc;
      r  = $urandom_range(0, 99);
      nb = (r < 40) ? $urandom_range(1, 8) :
           (r < 80) ? $urandom_range(9, 256) : $urandom_range(257, 8191);
      hi = 65535 / mx;
      if (hi > 8191) hi = 8191;
      if (nb > hi) nb = $urandom_range(1, hi);
      lo = (mx - 1) * nb + 1;
      hi = lo + 4 * mx * nb;
      if (hi > 65535 || $urandom_range(0, 1) == 0) hi = 65535;
      ms = $urandom_range(lo, hi);
      lo = (pc - 1) * nb + 1;
      hi = lo + 4 * pc * nb;
      if (hi > 65535 || $urandom_range(0, 1) == 0) hi = 65535;
      bc = $urandom_range(lo, hi);
      rr = GRID_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, pr - 1));
      cc = GRID_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, pc - 1));
    end else begin
      ms = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 65535);
      bc = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 65535);
      nb = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 8191);
      pr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 8);
      pc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 8);
      rr = GRID_W'(($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 8));
      cc = GRID_W'(($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 8));
    end
    write_reg(bcim_pkg::CFG_MATRIX_SIZE, ms[IDX_W-1:0]);
    write_reg(bcim_pkg::CFG_BAND_COUNT, bc[IDX_W-1:0]);
    write_reg(bcim_pkg::CFG_BLOCK_SIZE, nb[IDX_W-1:0]);
    write_reg(bcim_pkg::CFG_GRID_ROWS, pr[IDX_W-1:0]);
    write_reg(bcim_pkg::CFG_GRID_COLS, pc[IDX_W-1:0]);
    write_reg(bcim_pkg::CFG_MY_ROW, {8'd0, rr});
    write_reg(bcim_pkg::CFG_MY_COL, {8'd0, cc});
    cfg_valid <= 1'b0;
  endtask

  initial begin : main_seq
    logic                cfg_open;
    bcim_pkg::in_item_t  it;
    bcim_pkg::out_item_t probe_res;
    bcim_pkg::out_item_t ones;
    bcim_pkg::out_item_t big;
    int          cnt;
    int          l;
    int unsigned r;
    cfg_open = 1'b0;
    ones = result_of(16'd0, 1'b1, 16'd1, 16'd1, 16'd1, 32'd1, 32'd1, bcim_pkg::ST_OK);
    big  = result_of(16'd65534, 1'b1, 16'd65535, 16'd65535, 16'd65535,
                     32'hFFFE0001, 32'hFFFE0001, bcim_pkg::ST_OK);

    // After reset: one element, one block, one process
    add_req(bcim_pkg::REQ_ROW, 16'd0, 1'b1, ones);
    add_req(bcim_pkg::REQ_ROW, 16'd1, 1'b1,
            result_of(16'd0, 1'b0, 16'd1, 16'd1, 16'd1, 32'd1, 32'd1, bcim_pkg::ST_OK));
    add_req(bcim_pkg::REQ_COL, 16'hFFFF, 1'b1,
            result_of(16'd0, 1'b0, 16'd1, 16'd1, 16'd1, 32'd1, 32'd1, bcim_pkg::ST_OK));
    add_req(bcim_pkg::REQ_COL, 16'd0, 1'b1, ones);
    // Too few blocks with unit block size, then with a larger one
    add_cfg(bcim_pkg::CFG_GRID_ROWS, 16'd2);
    add_req(bcim_pkg::REQ_ROW, 16'd0, 1'b1,
            result_of('0, 1'b0, '0, '0, '0, '0, '0, bcim_pkg::ST_FATAL));
    add_cfg(bcim_pkg::CFG_BLOCK_SIZE, 16'd4);
    add_req(bcim_pkg::REQ_COL, 16'd5, 1'b1,
            result_of('0, 1'b0, '0, '0, '0, '0, '0, bcim_pkg::ST_RETRY));
    // Largest matrices on a single process: sizes hit their maximum
    add_cfg(bcim_pkg::CFG_MATRIX_SIZE, 16'hFFFF);
    add_cfg(bcim_pkg::CFG_BAND_COUNT, 16'hFFFF);
    add_cfg(bcim_pkg::CFG_BLOCK_SIZE, 16'd1);
    add_cfg(bcim_pkg::CFG_GRID_ROWS, 16'd1);
    add_req(bcim_pkg::REQ_ROW, 16'd65534, 1'b1, big);
    add_req(bcim_pkg::REQ_COL, 16'hFFFF, 1'b1,
            result_of(16'd0, 1'b0, 16'd65535, 16'd65535, 16'd65535,
                      32'hFFFE0001, 32'hFFFE0001, bcim_pkg::ST_OK));
    // Widest block on a 3x2 grid
    add_cfg(bcim_pkg::CFG_BLOCK_SIZE, 16'd8191);
    add_cfg(bcim_pkg::CFG_GRID_ROWS, 16'd3);
    add_cfg(bcim_pkg::CFG_GRID_COLS, 16'd2);
    add_cfg(bcim_pkg::CFG_MY_ROW, 16'd2);
    add_cfg(bcim_pkg::CFG_MY_COL, 16'd1);
    add_req(bcim_pkg::REQ_ROW, 16'd0, 1'b0, '0);
    add_req(bcim_pkg::REQ_ROW, 16'hFFFF, 1'b0, '0);
    add_req(bcim_pkg::REQ_COL, 16'd8190, 1'b0, '0);
    add_req(bcim_pkg::REQ_COL, 16'd8191, 1'b0, '0);
    // Row coordinate off the grid
    add_cfg(bcim_pkg::CFG_MY_ROW, 16'd255);
    add_req(bcim_pkg::REQ_ROW, 16'd0, 1'b0, '0);
    add_req(bcim_pkg::REQ_COL, 16'd0, 1'b0, '0);
    // Zero block size and zero grid columns count as one
    add_cfg(bcim_pkg::CFG_GRID_COLS, 16'd0);
    add_cfg(bcim_pkg::CFG_MY_COL, 16'd0);
    add_cfg(bcim_pkg::CFG_BLOCK_SIZE, 16'd0);
    add_cfg(bcim_pkg::CFG_GRID_ROWS, 16'd256);
    add_req(bcim_pkg::REQ_ROW, 16'd255, 1'b0, '0);
    add_req(bcim_pkg::REQ_ROW, 16'hFFFF, 1'b0, '0);
    add_req(bcim_pkg::REQ_COL, 16'd65534, 1'b0, '0);
    add_req(bcim_pkg::REQ_COL, 16'hFFFF, 1'b0, '0);
    // Zero matrix size, then zero band count
    add_cfg(bcim_pkg::CFG_MATRIX_SIZE, 16'd0);
    add_req(bcim_pkg::REQ_ROW, 16'd0, 1'b1,
            result_of('0, 1'b0, '0, '0, '0, '0, '0, bcim_pkg::ST_FATAL));
    add_cfg(bcim_pkg::CFG_GRID_ROWS, 16'd1);
    add_cfg(bcim_pkg::CFG_MATRIX_SIZE, 16'd100);
    add_cfg(bcim_pkg::CFG_BAND_COUNT, 16'd0);
    add_req(bcim_pkg::REQ_COL, 16'd3, 1'b1,
            result_of('0, 1'b0, '0, '0, '0, '0, '0, bcim_pkg::ST_FATAL));
    // Widest grid field value
    add_cfg(bcim_pkg::CFG_BAND_COUNT, 16'd100);
    add_cfg(bcim_pkg::CFG_GRID_ROWS, 16'd511);
    add_req(bcim_pkg::REQ_ROW, 16'd7, 1'b1,
            result_of('0, 1'b0, '0, '0, '0, '0, '0, bcim_pkg::ST_FATAL));
    add_cfg(bcim_pkg::CFG_BLOCK_SIZE, 16'd2);
    add_req(bcim_pkg::REQ_ROW, 16'd7, 1'b1,
            result_of('0, 1'b0, '0, '0, '0, '0, '0, bcim_pkg::ST_RETRY));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (!cfg_open) wait_idle();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      random_setup();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.req_type    = 1'($urandom_range(0, 1));
        it.local_index = '0;
        probe_res = map_index(it);
        cnt = (it.req_type == bcim_pkg::REQ_ROW) ? int'(probe_res.local_rows) :
                                                   int'(probe_res.local_cols);
        r = $urandom_range(0, 99);
        if (r < 65 && cnt > 0) l = int'($urandom_range(0, cnt - 1));
        else if (r < 75) l = cnt + int'($urandom_range(0, 2)) - 1;
        else l = int'($urandom_range(0, 65535));
        it.local_index = l[IDX_W-1:0];
        send_item(it, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver back-pressure: free-running, random, and long on/off runs
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      default: begin
        if (run_left == 0) begin
          out_stall <= ~out_stall;
          run_left = $urandom_range(1, 12);
        end else begin
          run_left--;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result transfer: %h", out_item);
      end else begin
        head_want = results_due.pop_front();
        if (head_want !== out_item) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("expected gi=%0d v=%0d rows=%0d cols=%0d bcols=%0d wf=%0d eij=%0d st=%0d",
                     head_want.global_index, head_want.index_valid, head_want.local_rows,
                     head_want.local_cols, head_want.local_band_cols,
                     head_want.wavefunction_size, head_want.eij_size, head_want.status);
            $display("actual   gi=%0d v=%0d rows=%0d cols=%0d bcols=%0d wf=%0d eij=%0d st=%0d",
                     out_item.global_index, out_item.index_valid, out_item.local_rows,
                     out_item.local_cols, out_item.local_band_cols,
                     out_item.wavefunction_size, out_item.eij_size, out_item.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
